>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/rme_pkg.sv
`default_nettype none
package rme_pkg;

  localparam int OPW   = 32;
  localparam int CELLW = 4;
  localparam int NCELL = OPW / CELLW;
  localparam int CNTW  = $clog2(OPW);
  localparam int REGW  = 32;

  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  typedef struct packed {
    logic            start;
    logic [OPW-1:0]  a;
    logic [OPW-1:0]  b;
  } mm_req_t;

  typedef struct packed {
    logic            done;
    logic [OPW-1:0]  result;
  } mm_resp_t;

endpackage
`default_nettype wire

>>> hw/rtl/rme_cell.sv
`default_nettype none
module rme_cell
  import rme_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             en,
  input  wire logic             dbl,
  input  wire logic             take_d,
  input  wire logic [CELLW-1:0] a_sl,
  input  wire logic [CELLW-1:0] m_sl,
  input  wire logic             cin,
  input  wire logic             bin,
  output logic                  cout,
  output logic                  bout,
  output logic [CELLW-1:0]      acc
);

  logic [CELLW-1:0] y;
  logic [CELLW:0]   sum;
  logic [CELLW:0]   diff;

  // Slice of acc + y, then of (acc + y) - m; carry and borrow ripple upward.
  always_comb begin
    y    = dbl ? acc : a_sl;
    sum  = {1'b0, acc} + {1'b0, y} + {{CELLW{1'b0}}, cin};
    cout = sum[CELLW];
    diff = {1'b0, sum[CELLW-1:0]} - {1'b0, m_sl} - {{CELLW{1'b0}}, bin};
    bout = diff[CELLW];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= take_d ? diff[CELLW-1:0] : sum[CELLW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rme_modmul.sv
`default_nettype none
module rme_modmul
  import rme_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [OPW-1:0] modulus,
  input  wire mm_req_t        req,
  output mm_resp_t            resp
);

  `include "assert_macros.svh"

  typedef enum logic [1:0] {IDLE, DBL, ADD} state_t;

  state_t          state;
  logic [OPW-1:0]  a_r;
  logic [OPW-1:0]  b_r;
  logic [CNTW-1:0] cnt;
  logic            done;
  logic            en;
  logic            dbl;
  logic            take_d;
  logic [NCELL:0]  carry;
  logic [NCELL:0]  borrow;
  logic [OPW-1:0]  acc;

  assign en  = (state == DBL) || (state == ADD);
  assign dbl = (state == DBL);
  assign carry[0]  = 1'b0;
  assign borrow[0] = 1'b0;
  // The sum is at most 2m-1, so one conditional subtract brings it below m.
  assign take_d = carry[NCELL] | ~borrow[NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rme_cell u_cell (
      .clk    (clk),
      .clr    (req.start),
      .en     (en),
      .dbl    (dbl),
      .take_d (take_d),
      .a_sl   (a_r[i*CELLW +: CELLW]),
      .m_sl   (modulus[i*CELLW +: CELLW]),
      .cin    (carry[i]),
      .bin    (borrow[i]),
      .cout   (carry[i+1]),
      .bout   (borrow[i+1]),
      .acc    (acc[i*CELLW +: CELLW])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (req.start) begin
            a_r   <= req.a;
            b_r   <= req.b;
            cnt   <= CNTW'(OPW - 1);
            state <= DBL;
          end
        end
        DBL: begin
          if (b_r[OPW-1]) begin
            state <= ADD;
          end else if (cnt == '0) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            cnt <= cnt - 1'b1;
            b_r <= b_r << 1;
          end
        end
        ADD: begin
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            cnt   <= cnt - 1'b1;
            b_r   <= b_r << 1;
            state <= DBL;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign resp.done   = done;
  assign resp.result = acc;

  `ASSERT_HOLDS(a_result_reduced, clk, rst, !done || modulus == '0 || acc < modulus, "modmul result not reduced")
  `ASSERT_NEVER(a_start_busy, clk, rst, req.start && state != IDLE, "modmul started while busy")
  `ASSERT_NEVER(a_done_busy, clk, rst, done && state != IDLE, "modmul done while still iterating")

endmodule
`default_nettype wire

>>> hw/rtl/rsa_modular_exponentiation.sv
// Channel   Handshake            Payload
// input     in_valid/in_stall    base_value, last_in
// output    out_valid/out_stall  power_result, last_out
// config    cfg_we               cfg_index, cfg_data
//
// The base is first reduced by one modular multiplication (base * 1 mod m). Each exponent
// bit passes through the control states EVAL and SHIFT, and FIN presents the result; a
// full 32-bit exponent needs 63 multiplications after the reduction, all done by the
// single shift-add multiplier.
// Reset is synchronous and clears control state; exponent resets to 0 and modulus to 1.
// The result waits in an output register, so a new item is taken while it is stalled.
`default_nettype none
module rsa_modular_exponentiation
  import rme_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [REGW-1:0] cfg_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [31:0]     base_value,
  input  wire logic            last_in,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [31:0]          power_result,
  output logic                 last_out
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {IDLE, RED, EVAL, PMUL, SHIFT, SMUL, FIN} state_t;

  state_t          state;
  logic [OPW-1:0]  exponent;
  logic [OPW-1:0]  modulus;
  logic [OPW-1:0]  e_work;
  logic [OPW-1:0]  sq;
  logic [OPW-1:0]  prod;
  logic            last_r;
  mm_req_t         req;
  mm_resp_t        resp;

  rme_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (req),
    .resp    (resp)
  );

  assign in_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      exponent  <= '0;
      modulus   <= OPW'(1);
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPONENT: exponent <= cfg_data[OPW-1:0];
          REG_MODULUS:  modulus  <= cfg_data[OPW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            last_r <= last_in;
            e_work <= exponent;
            prod   <= OPW'(1);
            if (exponent == '0) begin
              state <= FIN;
            end else begin
              // Reduce the base first: base * 1 mod m.
              req.start <= 1'b1;
              req.a     <= OPW'(1);
              req.b     <= base_value;
              state     <= RED;
            end
          end
        end
        RED: begin
          if (resp.done) begin
            sq    <= resp.result;
            state <= EVAL;
          end
        end
        EVAL: begin
          if (e_work[0]) begin
            req.start <= 1'b1;
            req.a     <= prod;
            req.b     <= sq;
            state     <= PMUL;
          end else begin
            state <= SHIFT;
          end
        end
        PMUL: begin
          if (resp.done) begin
            prod  <= resp.result;
            state <= SHIFT;
          end
        end
        SHIFT: begin
          e_work <= e_work >> 1;
          if ((e_work >> 1) == '0) begin
            state <= FIN;
          end else begin
            req.start <= 1'b1;
            req.a     <= sq;
            req.b     <= sq;
            state     <= SMUL;
          end
        end
        SMUL: begin
          if (resp.done) begin
            sq    <= resp.result;
            state <= EVAL;
          end
        end
        FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            power_result <= prod;
            last_out     <= last_r;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_HOLDS(a_result_from_fin, clk, rst, !$rose(out_valid) || $past(state == FIN), "result shown without finishing an item")
  `ASSERT_NEVER(a_done_unexpected, clk, rst, resp.done && state != RED && state != PMUL && state != SMUL, "multiplier finished with no request pending")
  `ASSERT_NEVER(a_exp_nonzero, clk, rst, (state == EVAL || state == SHIFT) && e_work == '0, "exponent exhausted inside the loop")

endmodule
`default_nettype wire

>>> sim/tb_rsa_modular_exponentiation.sv
`default_nettype none
module tb_rsa_modular_exponentiation;
  import rme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  typedef struct {
    logic [31:0] power;
    logic        last;
  } power_item_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic            cfg_index = REG_EXPONENT;
  logic [REGW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [31:0]     base_value = '0;
  logic            last_in = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [31:0]     power_result;
  logic            last_out;

  power_item_t     pending_powers[$];
  logic [31:0]     cur_exponent = 32'd0;
  logic [31:0]     cur_modulus = 32'd1;
  int              mismatches = 0;
  int              burst_left = 0;
  longint unsigned cycle_count = 0;

  rsa_modular_exponentiation DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .base_value(base_value), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_result(power_result), .last_out(last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A zero modulus wraps products at the operand width.
  function automatic longint unsigned mul_reduce(longint unsigned a, longint unsigned b,
                                                 longint unsigned m);
    if (m == 0) return (a * b) & 64'hFFFF_FFFF;
    return (a * b) % m;
  endfunction

  function automatic logic [31:0] modular_power(logic [31:0] base, logic [31:0] e_in,
                                                logic [31:0] m_in);
    longint unsigned m;
    longint unsigned e;
    longint unsigned sq;
    longint unsigned prod;
    m = m_in;
    e = e_in;
    if (e == 0) return 32'd1;
    sq = (m == 0) ? base : base % m;
    prod = (m == 1) ? 0 : 1;
    while (e != 0) begin
      if (e[0]) prod = mul_reduce(prod, sq, m);
      e = e >> 1;
      if (e != 0) sq = mul_reduce(sq, sq, m);
    end
    return prod[31:0];
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall pattern made of runs of free, random and solid stall.
  int stall_run = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    power_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (pending_powers.size() == 0) begin
        $error("unexpected transaction: power_result %h last_out %b", power_result, last_out);
        mismatches++;
      end else begin
        exp_item = pending_powers.pop_front();
        if (power_result !== exp_item.power) begin
          $error("power_result expected %h actual %h", exp_item.power, power_result);
          mismatches++;
        end
        if (last_out !== exp_item.last) begin
          $error("last_out expected %b actual %b", exp_item.last, last_out);
          mismatches++;
        end
      end
    end
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 50);
      stall_mode = $urandom_range(0, 2);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic wait_idle();
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EXPONENT) cur_exponent = value;
    else cur_modulus = value;
  endtask

  task automatic set_key(logic [31:0] e, logic [31:0] m);
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, m);
  endtask

  task automatic send_element(logic [31:0] base, logic last);
    power_item_t exp_item;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    base_value <= base;
    last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_item.power = modular_power(base, cur_exponent, cur_modulus);
    exp_item.last = last;
    pending_powers.push_back(exp_item);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_base(logic [31:0] m);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return (m == 0) ? $urandom : m - 1;
      3: return m;
      default: return $urandom;
    endcase
  endfunction

  // Reset values: exponent zero gives one, even with modulus one.
  task automatic test_reset_values();
    send_element(32'd0, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
    send_element(32'd12345, 1'b0);
    stop_sending();
  endtask

  task automatic test_directed();
    set_key(32'd1, 32'hFFFF_FFFF);
    send_element(32'd0, 1'b0);
    send_element(32'd1, 1'b1);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'hFFFF_FFFE, 1'b1);
    stop_sending();
    set_key(32'd0, 32'd13);
    send_element(32'd5, 1'b1);
    send_element(32'hFFFF_FFFF, 1'b0);
    stop_sending();
    set_key(32'd7, 32'd1);
    send_element(32'd9, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
    stop_sending();
    set_key(32'd2, 32'd7);
    send_element(32'd6, 1'b0);
    send_element(32'd7, 1'b1);
    send_element(32'hFFFF_FFFF, 1'b0);
    stop_sending();
    set_key(32'd65537, 32'd4294967291);
    send_element(32'd42, 1'b1);
    send_element(32'hFFFF_FFFA, 1'b0);
    stop_sending();
    set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_element(32'hFFFF_FFFE, 1'b1);
    send_element(32'd3, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b1);
    stop_sending();
    set_key(32'h8000_0000, 32'h8000_0001);
    send_element(32'h7FFF_FFFF, 1'b0);
    stop_sending();
  endtask

  // Phases with mostly random keys; most exponents are short to keep the run brief.
  task automatic test_random();
    logic [31:0] e;
    logic [31:0] m;
    int bits;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin e = 32'hFFFF_FFFF; m = $urandom; end
        1: begin e = 32'd3; m = 32'hFFFF_FFFF; end
        2: begin e = $urandom; m = $urandom_range(2, 300); end
        default: begin
          bits = $urandom_range(1, 16);
          e = $urandom & ((32'd1 << bits) - 1);
          m = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1000) : $urandom;
        end
      endcase
      if (m == 0) m = 32'd1;
      set_key(e, m);
      for (int n = 0; n < 30; n++) send_element(random_base(m), $urandom_range(0, 1));
      stop_sending();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
